// ===== src/drt_pkg.sv =====
// ----------------------------------------------------------------------------
// Repetend finder package
// Shared constants and the command and status words that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package drt_pkg;

  localparam int DefMaxDenominator = 64;
  localparam int NumW              = 6;
  localparam int DenW              = 7;
  localparam int DigitW            = 4;
  localparam int LenW              = 6;
  localparam int Radix             = 10;
  localparam int QBits             = 4;
  localparam int StepW             = $clog2(QBits);

  typedef struct packed {
    logic load_item;
    logic clr_step;
    logic rd_pos;
    logic wr_pos;
    logic div_start;
    logic div_step;
    logic emit_init;
    logic rd_digit;
    logic emit_load;
    logic res_load;
    logic res_bad;
  } drt_cmd_t;

  typedef struct packed {
    logic item_bad;
    logic num_zero;
    logic clr_last;
    logic pos_hit;
    logic div_last;
    logic div_end;
    logic emit_last;
    logic out_free;
  } drt_sts_t;

endpackage

// ===== src/drt_datapath.sv =====
// ----------------------------------------------------------------------------
// Repetend finder datapath
// Holds the remainder, the digit divider, the position and digit memories,
// and the output register.
// ----------------------------------------------------------------------------
module drt_datapath import drt_pkg::*; #(
  parameter int MaxDenominator = DefMaxDenominator
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  drt_cmd_t          cmd_i,
  output drt_sts_t          sts_o,
  input  logic [NumW-1:0]   numerator_i,
  input  logic [DenW-1:0]   denominator_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DigitW-1:0] digit_o,
  output logic [LenW-1:0]   cycle_length_o,
  output logic              terminates_o,
  output logic              bad_input_o,
  output logic              last_o
);

  localparam int RemW = $clog2(MaxDenominator);
  localparam int CntW = $clog2(MaxDenominator + 1);
  localparam int AccW = $clog2(Radix * MaxDenominator);

  logic [DenW-1:0]   den_q;
  logic [RemW-1:0]   rem_q;
  logic [CntW-1:0]   count_q;
  logic [RemW-1:0]   clr_idx_q;
  logic [AccW-1:0]   acc_q;
  logic [AccW-1:0]   acc_d;
  logic [AccW-1:0]   shifted_den;
  logic              acc_ge;
  logic [QBits-1:0]  quo_q;
  logic [QBits-1:0]  quo_d;
  logic [StepW-1:0]  step_q;
  logic [CntW-1:0]   pos_rd_q;
  logic [DigitW-1:0] dig_rd_q;
  logic [RemW-1:0]   emit_idx_q;
  logic [CntW-1:0]   emit_cnt_q;
  logic [CntW-1:0]   len_q;
  logic              out_valid_q;
  logic [DigitW-1:0] digit_q;
  logic [LenW-1:0]   out_len_q;
  logic              term_q;
  logic              bad_q;
  logic              last_q;
  logic              pos_we;
  logic [RemW-1:0]   pos_wa;
  logic [CntW-1:0]   pos_wd;

  logic [CntW-1:0]   pos_mem [MaxDenominator];
  logic [DigitW-1:0] dig_mem [MaxDenominator];

  assign shifted_den = AccW'(den_q) << step_q;
  assign acc_ge      = acc_q >= shifted_den;
  assign acc_d       = acc_ge ? acc_q - shifted_den : acc_q;
  assign quo_d       = quo_q | (QBits'(acc_ge) << step_q);

  assign sts_o.item_bad  = (denominator_i == '0)
                        || (32'(denominator_i) > 32'(MaxDenominator))
                        || (DenW'(numerator_i) >= denominator_i);
  assign sts_o.num_zero  = numerator_i == '0;
  assign sts_o.clr_last  = 32'(clr_idx_q) + 32'd1 == 32'(den_q);
  assign sts_o.pos_hit   = pos_rd_q != '0;
  assign sts_o.div_last  = step_q == '0;
  assign sts_o.div_end   = (acc_d == '0) || (32'(count_q) + 32'd1 == 32'(MaxDenominator));
  assign sts_o.emit_last = emit_cnt_q == CntW'(1);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      count_q   <= '0;
      clr_idx_q <= '0;
    end else begin
      if (cmd_i.load_item) begin
        rem_q     <= RemW'(numerator_i);
        count_q   <= '0;
        clr_idx_q <= '0;
      end
      if (cmd_i.clr_step) begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
      if (cmd_i.div_step && step_q == '0) begin
        rem_q   <= RemW'(acc_d);
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      den_q <= denominator_i;
    end
    if (cmd_i.div_start) begin
      acc_q  <= AccW'(rem_q) * AccW'(Radix);
      quo_q  <= '0;
      step_q <= StepW'(QBits - 1);
    end else if (cmd_i.div_step) begin
      acc_q  <= acc_d;
      quo_q  <= quo_d;
      step_q <= step_q - 1'b1;
    end
    if (cmd_i.emit_init) begin
      emit_idx_q <= RemW'(pos_rd_q - 1'b1);
      emit_cnt_q <= CntW'(count_q - pos_rd_q + 1'b1);
      len_q      <= CntW'(count_q - pos_rd_q + 1'b1);
    end else if (cmd_i.emit_load) begin
      emit_idx_q <= emit_idx_q + 1'b1;
      emit_cnt_q <= emit_cnt_q - 1'b1;
    end
  end

  always_comb begin
    pos_we = cmd_i.clr_step || cmd_i.wr_pos;
    pos_wa = cmd_i.clr_step ? clr_idx_q : rem_q;
    pos_wd = cmd_i.clr_step ? '0 : CntW'(count_q + 1'b1);
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    if (cmd_i.rd_pos) begin
      pos_rd_q <= pos_mem[rem_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step && step_q == '0) begin
      dig_mem[count_q[RemW-1:0]] <= DigitW'(quo_d);
    end
    if (cmd_i.rd_digit) begin
      dig_rd_q <= dig_mem[emit_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load || cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      digit_q   <= dig_rd_q;
      out_len_q <= LenW'(len_q);
      term_q    <= 1'b0;
      bad_q     <= 1'b0;
      last_q    <= emit_cnt_q == CntW'(1);
    end else if (cmd_i.res_load) begin
      digit_q   <= '0;
      out_len_q <= '0;
      term_q    <= !cmd_i.res_bad;
      bad_q     <= cmd_i.res_bad;
      last_q    <= 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign digit_o        = digit_q;
  assign cycle_length_o = out_len_q;
  assign terminates_o   = term_q;
  assign bad_input_o    = bad_q;
  assign last_o         = last_q;

  // A new word never overwrites one that is still waiting.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_load || cmd_i.res_load) |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

  // Emission never runs past the cycle length.
  a_emit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_load |-> emit_cnt_q != '0)
    else $error("emission count underflow");

  // A digit division only starts from a nonzero remainder.
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> rem_q != '0)
    else $error("division started on zero remainder");

endmodule

// ===== src/drt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Repetend finder controller
// Sequences clearing, long division, cycle detection and digit emission.
// ----------------------------------------------------------------------------
module drt_ctrl import drt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  drt_sts_t sts_i,
  output drt_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_EMRD  = 3'd5;
  localparam logic [2:0] S_EMOUT = 3'd6;
  localparam logic [2:0] S_RES   = 3'd7;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic       bad_q;
  logic       bad_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    bad_d   = bad_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          bad_d           = sts_i.item_bad;
          if (sts_i.item_bad || sts_i.num_zero) begin
            state_d = S_RES;
          end else begin
            state_d = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.rd_pos = 1'b1;
        state_d      = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.pos_hit) begin
          cmd_o.emit_init = 1'b1;
          state_d         = S_EMRD;
        end else begin
          cmd_o.wr_pos    = 1'b1;
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = sts_i.div_end ? S_RES : S_LOOK;
        end
      end
      S_EMRD: begin
        cmd_o.rd_digit = 1'b1;
        state_d        = S_EMOUT;
      end
      S_EMOUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (sts_i.emit_last) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_EMRD;
          end
        end
      end
      S_RES: begin
        cmd_o.res_bad = bad_q;
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      bad_q   <= bad_d;
    end
  end

  // A rejected fraction goes straight to its single result.
  a_bad_to_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && sts_i.item_bad) |=> (state_q == S_RES && bad_q))
    else $error("bad input not reported");

  // A remainder lookup is always followed by its check.
  a_look_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK) |=> (state_q == S_CHECK))
    else $error("lookup not followed by check");

endmodule

// ===== src/decimal_repetend_finder.sv =====
// Sequence: accept the fraction, clear the position table, then for each
// quotient digit a lookup, a check and four divider steps; a last lookup and
// check find the repeat, then each cycle digit is read and emitted while the
// output is ready; single results load once the output register is free.
// Throughput: one fraction at a time, bounded by the 1-bit-per-cycle divider.
// Reset: asynchronous, active low; returns to idle with the output empty.
// ----------------------------------------------------------------------------
// Decimal repetend finder
// Finds the repeating cycle of a proper fraction by long division and
// streams its digits, or reports a terminating or rejected fraction.
// ----------------------------------------------------------------------------
module decimal_repetend_finder import drt_pkg::*; #(
  parameter int MaxDenominator = DefMaxDenominator
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [NumW-1:0]   numerator_i,
  input  logic [DenW-1:0]   denominator_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DigitW-1:0] digit_o,
  output logic [LenW-1:0]   cycle_length_o,
  output logic              terminates_o,
  output logic              bad_input_o,
  output logic              last_o
);

  drt_cmd_t cmd;
  drt_sts_t sts;

  drt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  drt_datapath #(
    .MaxDenominator (MaxDenominator)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .numerator_i    (numerator_i),
    .denominator_i  (denominator_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .digit_o        (digit_o),
    .cycle_length_o (cycle_length_o),
    .terminates_o   (terminates_o),
    .bad_input_o    (bad_input_o),
    .last_o         (last_o)
  );

endmodule
